// File: rtl/rbsor_pkg.sv
// Shared types and constants for the red-black SOR Poisson solver.
`timescale 1ns / 1ps

package rbsor_pkg;

	typedef enum logic [1:0] {
		ACT_LOAD  = 2'd0,
		ACT_SOLVE = 2'd1,
		ACT_READ  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	localparam logic [1:0] REG_RELAX     = 2'd0;
	localparam logic [1:0] REG_SPACING   = 2'd1;
	localparam logic [1:0] REG_THRESHOLD = 2'd2;
	localparam logic [1:0] REG_MAX_SWEEP = 2'd3;

	localparam logic [16:0] RELAX_RESET   = 17'd120000;
	localparam logic [15:0] SPACING_RESET = 16'd164;
	localparam logic [31:0] THRESH_RESET  = 32'd17180;
	localparam logic [13:0] SWEEP_CAP     = 14'd10000;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_CHK,
		ST_GN,
		ST_GS,
		ST_GE,
		ST_GW,
		ST_WAIT,
		ST_WB,
		ST_PEND,
		ST_PCHK
	} state_t;

	typedef enum logic [1:0] {
		G_NONE,
		G_CENTER,
		G_FIRST,
		G_ADD
	} gather_t;

	typedef struct packed {
		gather_t gop;
		logic    ld_we;
		logic    host_rd;
		logic    clr_we;
		logic    rss_clr;
		logic    wb;
	} dp_cmd_t;

	typedef struct packed {
		logic act;
		logic below;
	} dp_stat_t;

endpackage

// File: rtl/rbsor_datapath.sv
// Datapath: grid memories, neighbor gather, relaxation pipeline and residual sum.
`timescale 1ns / 1ps

module rbsor_datapath #(
	parameter int ROWS = 64,
	parameter int COLS = 64,
	localparam int AW = $clog2(ROWS * COLS)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rbsor_pkg::dp_cmd_t  cmd,
	input  logic [AW-1:0]       addr,
	input  logic [5:0]          row,
	input  logic [5:0]          col,
	input  logic signed [31:0]  start_value,
	input  logic signed [31:0]  forcing,
	input  logic                active,
	input  logic [16:0]         relax_factor,
	input  logic [15:0]         spacing_squared,
	input  logic [31:0]         stop_threshold,
	output rbsor_pkg::dp_stat_t stat,
	output logic signed [31:0]  cell_value
);

	logic [31:0] vmem [ROWS*COLS];
	logic [31:0] fmem [ROWS*COLS];
	logic        amem [ROWS*COLS];

	logic               in_grid;
	logic [AW-1:0]      hk;
	logic [AW-1:0]      raddr;
	logic [AW-1:0]      waddr;
	logic               vwe;
	logic               awe;
	logic [31:0]        vwdata;
	logic               awdata;
	logic [31:0]        vrd_q;
	logic [31:0]        frd_q;
	logic               ard_q;
	logic               rd_res_q;

	logic signed [31:0] v_q;
	logic signed [31:0] force_q;
	logic signed [33:0] sum_q;
	logic signed [48:0] fprod_q;
	logic signed [32:0] f_q;
	logic signed [34:0] diff_s1;
	logic signed [33:0] dg_s2;
	logic [33:0]        mag_s3;
	logic signed [51:0] sp_s4;
	logic [63:0]        sq_s4;
	logic signed [35:0] rs_s5;
	logic [63:0]        rss_q;

	logic signed [48:0] fround;
	logic signed [34:0] dround;
	logic signed [51:0] sround;
	logic signed [36:0] newv_wide;
	logic signed [31:0] newv;
	logic [64:0]        rss_sum;

	assign in_grid = (32'(row) < ROWS) && (32'(col) < COLS);
	assign hk     = AW'(32'(row) * COLS + 32'(col));
	assign raddr  = cmd.host_rd ? hk : addr;
	assign waddr  = cmd.ld_we ? hk : addr;
	assign vwe    = (cmd.ld_we && in_grid) || cmd.wb;
	assign awe    = (cmd.ld_we && in_grid) || cmd.clr_we;
	assign vwdata = cmd.ld_we ? start_value : newv;
	assign awdata = cmd.ld_we ? active : 1'b0;

	always_ff @(posedge clk) begin
		if (vwe) begin
			vmem[waddr] <= vwdata;
		end
		if (cmd.ld_we && in_grid) begin
			fmem[hk] <= forcing;
		end
		if (awe) begin
			amem[waddr] <= awdata;
		end
		vrd_q <= vmem[raddr];
		frd_q <= fmem[raddr];
		ard_q <= amem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_res_q <= 1'b0;
		end else begin
			rd_res_q <= cmd.host_rd && in_grid;
		end
	end

	assign cell_value = rd_res_q ? vrd_q : 32'sd0;

	always_ff @(posedge clk) begin
		case (cmd.gop)
			rbsor_pkg::G_CENTER: begin
				v_q     <= vrd_q;
				force_q <= frd_q;
			end
			rbsor_pkg::G_FIRST: begin
				sum_q <= 34'($signed(vrd_q));
			end
			rbsor_pkg::G_ADD: begin
				sum_q <= sum_q + 34'($signed(vrd_q));
			end
			default: begin
			end
		endcase
	end

	assign fround    = fprod_q + 49'sd32768;
	assign dround    = diff_s1 + 35'sd2;
	assign sround    = sp_s4 + 52'sd32768;
	assign newv_wide = 37'(v_q) + 37'(rs_s5);
	assign newv      = (newv_wide > 37'sd2147483647) ? 32'sh7FFFFFFF :
		(newv_wide < -37'sd2147483648) ? 32'sh80000000 : newv_wide[31:0];
	assign rss_sum   = {1'b0, rss_q} + {1'b0, sq_s4};

	always_ff @(posedge clk) begin
		fprod_q <= force_q * $signed({1'b0, spacing_squared});
		f_q     <= fround[48:16];
		diff_s1 <= 35'(sum_q) - 35'(f_q);
		dg_s2   <= 34'($signed(dround[34:2])) - 34'(v_q);
		mag_s3  <= dg_s2[33] ? 34'(-dg_s2) : 34'(dg_s2);
		sp_s4   <= $signed({1'b0, relax_factor}) * dg_s2;
		sq_s4   <= (mag_s3[33:32] != 2'd0) ? 64'hFFFF_FFFF_FFFF_FFFF :
			64'(mag_s3[31:0]) * 64'(mag_s3[31:0]);
		rs_s5   <= sround[51:16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rss_q <= 64'd0;
		end else if (cmd.rss_clr) begin
			rss_q <= 64'd0;
		end else if (cmd.wb) begin
			rss_q <= rss_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : rss_sum[63:0];
		end
	end

	assign stat.act   = ard_q;
	assign stat.below = rss_q < {32'd0, stop_threshold};

endmodule

// File: rtl/rbsor_ctrl.sv
// Controller: host word decode, clearing pass, sweep sequencing and results.
`timescale 1ns / 1ps

module rbsor_ctrl #(
	parameter int ROWS = 64,
	parameter int COLS = 64,
	localparam int AW = $clog2(ROWS * COLS),
	localparam int RW = $clog2(ROWS),
	localparam int CW = $clog2(COLS)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [1:0]          action,
	input  logic [13:0]         max_sweeps,
	input  rbsor_pkg::dp_stat_t stat,
	output rbsor_pkg::dp_cmd_t  cmd,
	output logic [AW-1:0]       addr,
	output logic                busy,
	output logic                done,
	output logic [13:0]         sweeps_done,
	output logic                converged
);

	localparam logic [AW-1:0] LAST_CELL = AW'(ROWS * COLS - 1);
	localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 2);
	localparam logic [CW-1:0] LAST_COL  = CW'(COLS - 2);

	rbsor_pkg::state_t state_q, state_d;
	logic [RW-1:0] i_q, i_d;
	logic [CW-1:0] j_q, j_d;
	logic          par_q, par_d;
	logic [13:0]   cnt_q, cnt_d;
	logic [13:0]   lim_q, lim_d;
	logic [2:0]    wait_q, wait_d;
	logic [AW-1:0] clr_q, clr_d;
	logic          done_q, done_d;
	logic [13:0]   sweeps_q, sweeps_d;
	logic          conv_q, conv_d;

	logic          accept;
	logic [13:0]   lim_new;
	logic [AW-1:0] k;
	logic          j_last;
	logic          half_end;

	assign accept   = start && (state_q == rbsor_pkg::ST_IDLE);
	assign lim_new  = (max_sweeps > rbsor_pkg::SWEEP_CAP) ? rbsor_pkg::SWEEP_CAP : max_sweeps;
	assign k        = AW'(32'(i_q) * COLS + 32'(j_q));
	assign j_last   = (j_q == LAST_COL);
	assign half_end = j_last && (i_q == LAST_ROW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= rbsor_pkg::ST_CLEAR;
			i_q      <= '0;
			j_q      <= '0;
			par_q    <= 1'b0;
			cnt_q    <= '0;
			lim_q    <= '0;
			wait_q   <= '0;
			clr_q    <= '0;
			done_q   <= 1'b0;
			sweeps_q <= '0;
			conv_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			i_q      <= i_d;
			j_q      <= j_d;
			par_q    <= par_d;
			cnt_q    <= cnt_d;
			lim_q    <= lim_d;
			wait_q   <= wait_d;
			clr_q    <= clr_d;
			done_q   <= done_d;
			sweeps_q <= sweeps_d;
			conv_q   <= conv_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		i_d      = i_q;
		j_d      = j_q;
		par_d    = par_q;
		cnt_d    = cnt_q;
		lim_d    = lim_q;
		wait_d   = wait_q;
		clr_d    = clr_q;
		done_d   = 1'b0;
		sweeps_d = '0;
		conv_d   = 1'b0;
		cmd      = '{gop: rbsor_pkg::G_NONE, default: 1'b0};
		addr     = k;
		case (state_q)
			rbsor_pkg::ST_CLEAR: begin
				addr       = clr_q;
				cmd.clr_we = 1'b1;
				clr_d      = clr_q + 1'b1;
				if (clr_q == LAST_CELL) begin
					state_d = rbsor_pkg::ST_IDLE;
				end
			end
			rbsor_pkg::ST_IDLE: begin
				if (accept) begin
					case (rbsor_pkg::action_t'(action))
						rbsor_pkg::ACT_LOAD: begin
							cmd.ld_we = 1'b1;
							done_d    = 1'b1;
						end
						rbsor_pkg::ACT_READ: begin
							cmd.host_rd = 1'b1;
							done_d      = 1'b1;
						end
						rbsor_pkg::ACT_SOLVE: begin
							cnt_d       = '0;
							lim_d       = lim_new;
							cmd.rss_clr = 1'b1;
							if (lim_new == 14'd0) begin
								done_d = 1'b1;
							end else begin
								i_d     = RW'(1);
								j_d     = CW'(1);
								par_d   = 1'b0;
								state_d = rbsor_pkg::ST_SCAN;
							end
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
				end
			end
			rbsor_pkg::ST_SCAN: begin
				if ((i_q[0] ^ j_q[0]) != par_q) begin
					state_d = rbsor_pkg::ST_WB;
				end else begin
					state_d = rbsor_pkg::ST_CHK;
				end
			end
			rbsor_pkg::ST_CHK: begin
				cmd.gop = rbsor_pkg::G_CENTER;
				addr    = k - AW'(COLS);
				state_d = stat.act ? rbsor_pkg::ST_GN : rbsor_pkg::ST_WB;
			end
			rbsor_pkg::ST_GN: begin
				cmd.gop = rbsor_pkg::G_FIRST;
				addr    = k + AW'(COLS);
				state_d = rbsor_pkg::ST_GS;
			end
			rbsor_pkg::ST_GS: begin
				cmd.gop = rbsor_pkg::G_ADD;
				addr    = k + AW'(1);
				state_d = rbsor_pkg::ST_GE;
			end
			rbsor_pkg::ST_GE: begin
				cmd.gop = rbsor_pkg::G_ADD;
				addr    = k - AW'(1);
				state_d = rbsor_pkg::ST_GW;
			end
			rbsor_pkg::ST_GW: begin
				cmd.gop = rbsor_pkg::G_ADD;
				wait_d  = '0;
				state_d = rbsor_pkg::ST_WAIT;
			end
			rbsor_pkg::ST_WAIT: begin
				wait_d = wait_q + 1'b1;
				if (wait_q == 3'd4) begin
					state_d = rbsor_pkg::ST_WB;
				end
			end
			rbsor_pkg::ST_WB: begin
				// Skipped cells also pass through here to advance, without writing.
				cmd.wb = (wait_q == 3'd5);
				wait_d = '0;
				if (!half_end) begin
					j_d     = j_last ? CW'(1) : j_q + 1'b1;
					i_d     = j_last ? i_q + 1'b1 : i_q;
					state_d = rbsor_pkg::ST_SCAN;
				end else if (!par_q) begin
					par_d   = 1'b1;
					i_d     = RW'(1);
					j_d     = CW'(1);
					state_d = rbsor_pkg::ST_SCAN;
				end else begin
					state_d = rbsor_pkg::ST_PEND;
				end
			end
			rbsor_pkg::ST_PEND: begin
				cnt_d   = cnt_q + 1'b1;
				state_d = rbsor_pkg::ST_PCHK;
			end
			rbsor_pkg::ST_PCHK: begin
				if (stat.below || (cnt_q == lim_q)) begin
					done_d   = 1'b1;
					sweeps_d = cnt_q;
					conv_d   = stat.below;
					state_d  = rbsor_pkg::ST_IDLE;
				end else begin
					cmd.rss_clr = 1'b1;
					i_d         = RW'(1);
					j_d         = CW'(1);
					par_d       = 1'b0;
					state_d     = rbsor_pkg::ST_SCAN;
				end
			end
			default: begin
				state_d = rbsor_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy        = (state_q != rbsor_pkg::ST_IDLE);
	assign done        = done_q;
	assign sweeps_done = sweeps_q;
	assign converged   = conv_q;

endmodule

// File: rtl/red_black_sor_poisson_solver.sv
// Top level of the red-black SOR Poisson solver: configuration registers and wiring.
`timescale 1ns / 1ps

// Usage: a word is taken at a clock edge where start is high and busy is low.
// action selects load cell, run solve or read cell; row and col address a cell.
// Every word gives one result word, shown for exactly one cycle with done high.
// Load and read words leave busy low, so they can follow each other every
// cycle; a read returns cell_value the cycle after it is taken.
// A solve holds busy high for all its sweep pairs. In each half sweep every
// interior cell passes SCAN and WB when of the other color, also CHK when
// inactive, and also GN, GS, GE, GW and WAIT when relaxed (five reads on the
// single value memory port plus the arithmetic pipeline). The stop test adds
// PEND and PCHK per sweep pair; the result word follows the cycle after PCHK.
// After reset the active map is cleared, one cell per cycle, with busy high
// until the last cell; configuration writes are taken at any time.
// The receiver cannot stall; done is a one-cycle strobe.

module red_black_sor_poisson_solver #(
	parameter int ROWS = 64,
	parameter int COLS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         action,
	input  logic [5:0]         row,
	input  logic [5:0]         col,
	input  logic signed [31:0] start_value,
	input  logic signed [31:0] forcing,
	input  logic               active,
	output logic               done,
	output logic signed [31:0] cell_value,
	output logic [13:0]        sweeps_done,
	output logic               converged,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	localparam int AW = $clog2(ROWS * COLS);

	logic [16:0] relax_q;
	logic [15:0] spacing_q;
	logic [31:0] thresh_q;
	logic [13:0] max_sweeps_q;

	rbsor_pkg::dp_cmd_t  cmd;
	rbsor_pkg::dp_stat_t stat;
	logic [AW-1:0]       addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relax_q      <= rbsor_pkg::RELAX_RESET;
			spacing_q    <= rbsor_pkg::SPACING_RESET;
			thresh_q     <= rbsor_pkg::THRESH_RESET;
			max_sweeps_q <= rbsor_pkg::SWEEP_CAP;
		end else if (cfg_we) begin
			case (cfg_index)
				rbsor_pkg::REG_RELAX:     relax_q      <= cfg_data[16:0];
				rbsor_pkg::REG_SPACING:   spacing_q    <= cfg_data[15:0];
				rbsor_pkg::REG_THRESHOLD: thresh_q     <= cfg_data;
				rbsor_pkg::REG_MAX_SWEEP: max_sweeps_q <= cfg_data[13:0];
				default: begin
				end
			endcase
		end
	end

	rbsor_ctrl #(
		.ROWS(ROWS),
		.COLS(COLS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.action     (action),
		.max_sweeps (max_sweeps_q),
		.stat       (stat),
		.cmd        (cmd),
		.addr       (addr),
		.busy       (busy),
		.done       (done),
		.sweeps_done(sweeps_done),
		.converged  (converged)
	);

	rbsor_datapath #(
		.ROWS(ROWS),
		.COLS(COLS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.addr           (addr),
		.row            (row),
		.col            (col),
		.start_value    (start_value),
		.forcing        (forcing),
		.active         (active),
		.relax_factor   (relax_q),
		.spacing_squared(spacing_q),
		.stop_threshold (thresh_q),
		.stat           (stat),
		.cell_value     (cell_value)
	);

`ifndef SYNTHESIS
	a_quick_word: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (action != rbsor_pkg::ACT_SOLVE)) |=> (done && !busy))
		else $error("load or read word gave no result on the next cycle");

	a_conv_result: assert property (@(posedge clk) disable iff (!arst_n)
		converged |-> (done && (sweeps_done != 14'd0)))
		else $error("converged flag outside a solve result");

	a_sweep_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (sweeps_done <= rbsor_pkg::SWEEP_CAP))
		else $error("sweep count beyond the cap");

	a_solve_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (action == rbsor_pkg::ACT_SOLVE) && (max_sweeps_q != 14'd0))
		|=> busy)
		else $error("solve word did not occupy the block");
`endif

endmodule
